// ===== sv/rlpg_pkg.sv =====
// rlpg_pkg: types, constants and small functions of the rainbow led pattern generator
// no dependencies; imported by the channel interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none

package rlpg_pkg;

   // field widths
   localparam int REQ_TYPE_W = 2;
   localparam int TIME_W     = 64;
   localparam int CHAN_W     = 8;
   localparam int IDX_W      = 6;
   localparam int GRB_W      = 24;
   localparam int HUE_W      = 11;
   localparam int SPEED_W    = 7;
   localparam int LEVEL_W    = 4;
   localparam int INTERVAL_W = 24;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   typedef logic [REQ_TYPE_W-1:0] req_kind_type;
   typedef logic [CHAN_W-1:0]     chan_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;

   typedef struct packed {
      chan_type r;
      chan_type g;
      chan_type b;
   } rgb_type;

   // request kinds
   localparam req_kind_type REQ_FRAME     = 2'd0;
   localparam req_kind_type REQ_STIMULATE = 2'd1;
   localparam req_kind_type REQ_LOGO      = 2'd2;

   // register indexes
   localparam csr_idx_type CSR_BRIGHTNESS = 2'd0;
   localparam csr_idx_type CSR_DECAY_INT  = 2'd1;
   localparam csr_idx_type CSR_SPEED_MIN  = 2'd2;
   localparam csr_idx_type CSR_SPEED_MAX  = 2'd3;

   // reset values
   localparam logic [LEVEL_W-1:0]    BRIGHTNESS_RST = 4'd8;
   localparam logic [INTERVAL_W-1:0] DECAY_INT_RST  = 24'd200000;
   localparam logic [SPEED_W-1:0]    SPEED_MIN_RST  = 7'd4;
   localparam logic [SPEED_W-1:0]    SPEED_MAX_RST  = 7'd100;
   localparam logic [SPEED_W-1:0]    SPEED_RST      = 7'd4;

   // color wheel: six sectors of 256 steps
   localparam logic [HUE_W:0] WHEEL_STEPS = 12'd1536;

   // speed * 95 / 100 as speed * (95 * 2^17 / 100, rounded up) >> 17, exact for 7-bit speed
   localparam int              DECAY_SHIFT = 17;
   localparam logic [23:0]     DECAY_MUL   = 24'd124519;

   // brightness step, saturating at full scale
   function automatic chan_type level_step(input logic [LEVEL_W-1:0] lvl);
      chan_type step;
      case (lvl)
         4'd0:    step = 8'd0;
         4'd1:    step = 8'd32;
         4'd2:    step = 8'd64;
         4'd3:    step = 8'd96;
         4'd4:    step = 8'd128;
         4'd5:    step = 8'd160;
         4'd6:    step = 8'd192;
         4'd7:    step = 8'd224;
         default: step = 8'd255;
      endcase
      return step;
   endfunction

   // raw wheel color for a position below WHEEL_STEPS
   function automatic rgb_type wheel_color(input logic [HUE_W-1:0] pos);
      rgb_type  c;
      chan_type up;
      chan_type down;
      up   = pos[7:0];
      down = 8'd255 - pos[7:0];
      case (pos[10:8])
         3'd0:    c = '{r: up,     g: 8'd0,   b: 8'd255};
         3'd1:    c = '{r: 8'd255, g: 8'd0,   b: down};
         3'd2:    c = '{r: 8'd255, g: up,     b: 8'd0};
         3'd3:    c = '{r: down,   g: 8'd255, b: 8'd0};
         3'd4:    c = '{r: 8'd0,   g: 8'd255, b: up};
         default: c = '{r: 8'd0,   g: down,   b: 8'd255};
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== sv/rlpg_if.sv =====
// rlpg_req_if and rlpg_rsp_if: valid/ready channels of the rainbow led pattern generator
// depends on rlpg_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface rlpg_req_if;
   import rlpg_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [TIME_W-1:0]     now_us;
   logic [CHAN_W-1:0]     red_in;
   logic [CHAN_W-1:0]     green_in;
   logic [CHAN_W-1:0]     blue_in;

   modport source (output valid, req_type, now_us, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, req_type, now_us, red_in, green_in, blue_in, output ready);
endinterface

interface rlpg_rsp_if;
   import rlpg_pkg::*;

   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] led_index;
   logic [GRB_W-1:0] color_grb;
   logic             last;

   modport source (output valid, led_index, color_grb, last, input ready);
   modport sink   (input valid, led_index, color_grb, last, output ready);
endinterface

`default_nettype wire

// ===== sv/rainbow_led_pattern_generator.sv =====
// rainbow_led_pattern_generator: hsv color wheel led effects with brightness and gamma
// depends on rlpg_pkg and the channel interfaces in rlpg_if.sv
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    req_type, now_us, red_in, green_in, blue_in
//   rsp_chan  out  valid/ready    led_index, color_grb, last
//   csr_*     in   csr_we only    csr_index, csr_wdata
//
// a stimulate or unknown request leaves the sequencer idle; a frame or logo request holds ready low
// until its last item is taken. each frame led color, and the one color of a logo request, goes
// through one shared 9x9 multiplier, twice per channel (brightness scale, then gamma square);
// further logo items repeat that color with no new pass. a stall on rsp_chan holds the item and
// the sequencer. reset is synchronous.
`timescale 1ns / 1ps
`default_nettype none

module rainbow_led_pattern_generator #(
   parameter int EFFECT_LED_COUNT = 8,
   parameter int EFFECT_LED_FIRST = 46,
   parameter int LOGO_LED_COUNT   = 4,
   parameter int LOGO_LED_FIRST   = 18,
   parameter int HUE_PITCH        = 151
) (
   input  logic                              clock,
   input  logic                              reset,
   rlpg_req_if.sink                          req_chan,
   rlpg_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [rlpg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rlpg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rlpg_pkg::*;

   localparam int MAX_COUNT = (EFFECT_LED_COUNT > LOGO_LED_COUNT) ?
                              EFFECT_LED_COUNT : LOGO_LED_COUNT;
   localparam int CNT_W     = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
   localparam logic [CNT_W-1:0] EFFECT_LAST = CNT_W'(EFFECT_LED_COUNT - 1);
   localparam logic [CNT_W-1:0] LOGO_LAST   = CNT_W'(LOGO_LED_COUNT - 1);
   localparam logic [HUE_W-1:0] PITCH       = HUE_W'(HUE_PITCH);
   localparam logic [IDX_W-1:0] EFFECT_BASE = IDX_W'(EFFECT_LED_FIRST);
   localparam logic [IDX_W-1:0] LOGO_BASE   = IDX_W'(LOGO_LED_FIRST);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_SQR  = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   // channel order through the shared unit
   localparam logic [1:0] CH_GREEN = 2'd0;
   localparam logic [1:0] CH_RED   = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   logic [2:0]            state_ff, state_in;
   logic [1:0]            ch_ff, ch_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  frame_ff, frame_in;
   logic [LEVEL_W-1:0]    bright_ff, bright_in;
   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic [SPEED_W-1:0]    speed_min_ff, speed_min_in;
   logic [SPEED_W-1:0]    speed_max_ff, speed_max_in;
   logic [HUE_W-1:0]      hue_ff, hue_in;
   logic [SPEED_W-1:0]    speed_ff, speed_in;
   logic [TIME_W-1:0]     next_decay_ff, next_decay_in;
   logic [HUE_W-1:0]      pos_ff, pos_in;
   rgb_type               logo_ff, logo_in;
   logic [16:0]           prod_ff, prod_in;
   chan_type              g_ff, g_in, r_ff, r_in, b_ff, b_in;

   logic [HUE_W:0]        hue_sum;
   logic [HUE_W-1:0]      hue_next;
   logic [HUE_W:0]        pos_sum;
   logic [HUE_W-1:0]      pos_next;
   logic [23:0]           decay_prod;
   rgb_type               wheel;
   rgb_type               src_rgb;
   chan_type              src;
   logic [16:0]           div_sum;
   logic [8:0]            s_plus1;
   logic [8:0]            op_a, op_b;
   logic [17:0]           mul_res;
   logic [16:0]           prod_m1;
   chan_type              shade_val;
   logic [CNT_W-1:0]      last_cnt;
   logic                  is_last;

   // hue rotator and per-led wheel position, both modulo the wheel size
   assign hue_sum  = {1'b0, hue_ff} + {{(HUE_W+1-SPEED_W){1'b0}}, speed_ff};
   assign hue_next = (hue_sum >= WHEEL_STEPS) ? HUE_W'(hue_sum - WHEEL_STEPS) : hue_sum[HUE_W-1:0];
   assign pos_sum  = {1'b0, pos_ff} + {1'b0, PITCH};
   assign pos_next = (pos_sum >= WHEEL_STEPS) ? HUE_W'(pos_sum - WHEEL_STEPS) : pos_sum[HUE_W-1:0];

   // speed decay to 95 percent
   assign decay_prod = 24'(speed_ff) * DECAY_MUL;

   // channel source for the current step
   assign wheel   = wheel_color(pos_ff);
   assign src_rgb = frame_ff ? wheel : logo_ff;
   always_comb begin
      case (ch_ff)
         CH_GREEN: src = src_rgb.g;
         CH_RED:   src = src_rgb.r;
         default:  src = src_rgb.b;
      endcase
   end

   // shared unit: x / 255 by add and shift, then one 9x9 multiplier
   assign div_sum   = {1'b0, prod_ff[15:0]} + 17'(prod_ff[15:8]) + 17'd1;
   assign s_plus1   = {1'b0, div_sum[15:8]} + 9'd1;
   assign op_a      = (state_ff == ST_SQR) ? s_plus1 : {1'b0, src};
   assign op_b      = (state_ff == ST_SQR) ? s_plus1 : {1'b0, level_step(bright_ff)};
   assign mul_res   = op_a * op_b;
   assign prod_m1   = prod_ff - 17'd1;
   assign shade_val = prod_m1[15:8];

   assign last_cnt = frame_ff ? EFFECT_LAST : LOGO_LAST;
   assign is_last  = (cnt_ff == last_cnt);

   // next state of the sequencer, the led state and the registers
   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      cnt_in        = cnt_ff;
      frame_in      = frame_ff;
      bright_in     = bright_ff;
      interval_in   = interval_ff;
      speed_min_in  = speed_min_ff;
      speed_max_in  = speed_max_ff;
      hue_in        = hue_ff;
      speed_in      = speed_ff;
      next_decay_in = next_decay_ff;
      pos_in        = pos_ff;
      logo_in       = logo_ff;
      prod_in       = prod_ff;
      g_in          = g_ff;
      r_in          = r_ff;
      b_in          = b_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               case (req_chan.req_type)
                  REQ_FRAME: begin
                     hue_in   = hue_next;
                     pos_in   = hue_next;
                     frame_in = 1'b1;
                     cnt_in   = '0;
                     ch_in    = CH_GREEN;
                     state_in = ST_MUL;
                     if (req_chan.now_us >= next_decay_ff) begin
                        next_decay_in = req_chan.now_us + TIME_W'(interval_ff);
                        if (speed_ff > speed_min_ff) begin
                           speed_in = decay_prod[DECAY_SHIFT +: SPEED_W];
                        end
                     end
                  end
                  REQ_STIMULATE: begin
                     if (speed_ff < speed_max_ff) begin
                        speed_in = speed_ff + 7'd1;
                     end
                  end
                  REQ_LOGO: begin
                     logo_in  = '{r: req_chan.red_in, g: req_chan.green_in,
                                  b: req_chan.blue_in};
                     frame_in = 1'b0;
                     cnt_in   = '0;
                     ch_in    = CH_GREEN;
                     state_in = ST_MUL;
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            // finish the previous channel while scaling this one
            case (ch_ff)
               CH_RED:  g_in = shade_val;
               CH_BLUE: r_in = shade_val;
               default: ;
            endcase
            prod_in  = mul_res[16:0];
            state_in = ST_SQR;
         end
         ST_SQR: begin
            prod_in = mul_res[16:0];
            if (ch_ff == CH_BLUE) begin
               state_in = ST_FIN;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_FIN: begin
            b_in     = shade_val;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_chan.ready) begin
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
                  if (frame_ff) begin
                     pos_in   = pos_next;
                     ch_in    = CH_GREEN;
                     state_in = ST_MUL;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // register writes
      if (csr_we) begin
         case (csr_index)
            CSR_BRIGHTNESS: bright_in    = csr_wdata[LEVEL_W-1:0];
            CSR_DECAY_INT:  interval_in  = csr_wdata[INTERVAL_W-1:0];
            CSR_SPEED_MIN:  speed_min_in = csr_wdata[SPEED_W-1:0];
            CSR_SPEED_MAX:  speed_max_in = csr_wdata[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   // control state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ch_ff         <= CH_GREEN;
         cnt_ff        <= '0;
         frame_ff      <= 1'b0;
         bright_ff     <= BRIGHTNESS_RST;
         interval_ff   <= DECAY_INT_RST;
         speed_min_ff  <= SPEED_MIN_RST;
         speed_max_ff  <= SPEED_MAX_RST;
         hue_ff        <= '0;
         speed_ff      <= SPEED_RST;
         next_decay_ff <= '0;
         pos_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         ch_ff         <= ch_in;
         cnt_ff        <= cnt_in;
         frame_ff      <= frame_in;
         bright_ff     <= bright_in;
         interval_ff   <= interval_in;
         speed_min_ff  <= speed_min_in;
         speed_max_ff  <= speed_max_in;
         hue_ff        <= hue_in;
         speed_ff      <= speed_in;
         next_decay_ff <= next_decay_in;
         pos_ff        <= pos_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      logo_ff <= logo_in;
      prod_ff <= prod_in;
      g_ff    <= g_in;
      r_ff    <= r_in;
      b_ff    <= b_in;
   end

   // channel outputs
   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = (state_ff == ST_OUT);
   assign rsp_chan.led_index = (frame_ff ? EFFECT_BASE : LOGO_BASE) + IDX_W'(cnt_ff);
   assign rsp_chan.color_grb = {g_ff, r_ff, b_ff};
   assign rsp_chan.last      = is_last;

   // checks
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, hue_ff} < WHEEL_STEPS) && ({1'b0, pos_ff} < WHEEL_STEPS))
      else $error("hue or wheel position out of range");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (cnt_ff <= last_cnt))
      else $error("led count beyond the last led");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last) |=> req_chan.ready)
      else $error("not idle after the last item");

   a_no_early_out: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !rsp_chan.valid)
      else $error("item shown before its color was computed");

endmodule

`default_nettype wire
